// ===== design/ibc_pkg.sv =====
// Shared constants, register codes and weight helpers for the image blur convolution block.
package ibc_pkg;

    localparam int PIX_W          = 16;
    localparam int WT_W           = 17;
    localparam int WT_FRAC        = 16;
    localparam int Q16_ONE        = 65536;
    localparam int ROW_W          = 17;
    localparam int HEIGHT_W       = 16;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;
    localparam int RECIP_SHIFT    = 26;
    localparam int RECIP_W        = 24;
    localparam int FIFO_DEPTH     = 8;
    localparam int DEF_MAX_KERNEL = 7;
    localparam int DEF_MAX_WIDTH  = 4096;

    localparam logic [2:0] REG_KERNEL_TYPE   = 3'd0;
    localparam logic [2:0] REG_KERNEL_SIZE   = 3'd1;
    localparam logic [2:0] REG_CENTER_WEIGHT = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [1:0] KT_WEIGHTED = 2'd1;
    localparam logic [1:0] KT_BINOMIAL = 2'd2;

    // Entry k of row n of Pascal's triangle (zero beyond the row).
    function automatic int unsigned binom_coef(input int unsigned n, input int unsigned k);
        int unsigned row [16];
        int unsigned m;
        int unsigned j;
        for (j = 0; j < 16; j++)
        begin
            row[j] = 0;
        end
        row[0] = 1;
        for (m = 1; m <= n && m < 16; m++)
        begin
            for (j = m; j >= 1; j--)
            begin
                row[j] = row[j] + row[j - 1];
            end
        end
        return (k < 16) ? row[k] : 0;
    endfunction

    // Normalised binomial weight in Q1.16 for half size o at window place (a, d).
    function automatic int unsigned binom_weight(input int unsigned o, input int unsigned a,
                                                 input int unsigned d);
        int unsigned e;
        int unsigned prod;
        e    = 4 * o;
        prod = binom_coef(2 * o, a) * binom_coef(2 * o, d);
        return (e <= 16) ? (prod << (16 - e)) : (prod >> (e - 16));
    endfunction

endpackage

// ===== design/ibc_line_store.sv =====
// Line store: one memory word per column holding the pixels of the previous rows.
module ibc_line_store #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_WIDTH  = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
    input  logic                       wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    input  logic [ibc_pkg::PIX_W-1:0]  wr_pix,
    output logic [ibc_pkg::PIX_W-1:0]  column [MAX_KERNEL]
);
    import ibc_pkg::*;

    localparam int LR = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int LW = LR * PIX_W;

    logic [LW-1:0] mem [MAX_WIDTH];
    logic [LW-1:0] rd_reg;
    logic [LW-1:0] fwd_reg;
    logic          hit_reg;
    logic [LW-1:0] cur;
    logic [LW-1:0] wr_word;

    // Take the word just written when the read hit the same column in the same cycle.
    assign cur = hit_reg ? fwd_reg : rd_reg;

    always_comb
    begin
        wr_word = '0;
        wr_word[0 +: PIX_W] = wr_pix;
        for (int k = 1; k < LR; k++)
        begin
            wr_word[k * PIX_W +: PIX_W] = cur[(k - 1) * PIX_W +: PIX_W];
        end
    end

    always_comb
    begin
        column[0] = wr_pix;
        for (int k = 1; k < MAX_KERNEL; k++)
        begin
            column[k] = cur[(k - 1) * PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[rd_col];
        end
        if (wr_en)
        begin
            mem[wr_col] <= wr_word;
        end
        fwd_reg <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= rd_en && wr_en && (rd_col == wr_col);
        end
    end

endmodule

// ===== design/ibc_cell.sv =====
// Window cell: one column of the window, its weighted products and their sum.
module ibc_cell #(
    parameter int MAX_KERNEL = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift_en,
    input  logic [ibc_pkg::PIX_W-1:0] col_in  [MAX_KERNEL],
    output logic [ibc_pkg::PIX_W-1:0] col_out [MAX_KERNEL],
    input  logic [ibc_pkg::WT_W-1:0]  wt      [MAX_KERNEL],
    input  logic                      col_ok,
    input  logic [MAX_KERNEL-1:0]     row_ok,
    output logic [ibc_pkg::PIX_W+ibc_pkg::WT_W+$clog2(MAX_KERNEL+1)-1:0] sum
);
    import ibc_pkg::*;

    localparam int PROD_W = PIX_W + WT_W;
    localparam int CSW    = PROD_W + $clog2(MAX_KERNEL + 1);

    logic [PIX_W-1:0]  col_reg  [MAX_KERNEL];
    logic [PROD_W-1:0] prod_reg [MAX_KERNEL];
    logic [CSW-1:0]    sum_reg;
    logic [CSW-1:0]    sum_next;

    assign col_out = col_reg;
    assign sum     = sum_reg;

    // Advance the column one place down the row on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_KERNEL; d++)
            begin
                col_reg[d] <= '0;
            end
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int d = 0; d < MAX_KERNEL; d++)
        begin
            sum_next = sum_next + CSW'(prod_reg[d]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < MAX_KERNEL; d++)
        begin
            prod_reg[d] <= (col_ok && row_ok[d]) ? PROD_W'(wt[d]) * PROD_W'(col_reg[d]) : '0;
        end
        sum_reg <= sum_next;
    end

endmodule

// ===== design/ibc_out_fifo.sv =====
// Result queue between the arithmetic pipeline and the output channel.
module ibc_out_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [ibc_pkg::PIX_W-1:0] push_data,
    input  logic                      push_last,
    output logic                      valid,
    input  logic                      stall,
    output logic [ibc_pkg::PIX_W-1:0] data,
    output logic                      last
);
    import ibc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PIX_W-1:0] data_reg [DEPTH];
    logic             last_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign valid = (count_reg != '0);
    assign pop   = valid && !stall;
    assign data  = data_reg[rd_ptr_reg];
    assign last  = last_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
            last_reg[wr_ptr_reg] <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

// ===== design/image_blur_convolution.sv =====
// Top level: register port, frame counters, weight table, window cell row and result queue.
// A taken input word passes the window column, product, sum and total registers to the queue.
// Throughput: one pixel word per cycle unless held off; the line store reads one column while
// it writes back the column of the previous word, so nothing waits on the read-modify-write.
// Input is held off only while the eight-entry result queue and words in flight fill it.
// Reset clears counters, window and queue; registers return to mean, size 3, ff 0.5, 1024x768.
module image_blur_convolution #(
    parameter int MAX_KERNEL = ibc_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH  = ibc_pkg::DEF_MAX_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ibc_pkg::ADDR_W-1:0] paddr,
    input  logic [ibc_pkg::DATA_W-1:0] pwdata,
    output logic [ibc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  logic [ibc_pkg::PIX_W-1:0]  pixel,
    input  logic                       flush,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [ibc_pkg::PIX_W-1:0]  blurred,
    output logic                       last
);
    import ibc_pkg::*;

    localparam int HALF   = (MAX_KERNEL - 1) / 2;
    localparam int OW     = (HALF > 0) ? $clog2(HALF + 1) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int LW     = $clog2(HALF * MAX_WIDTH + HALF + 2);
    localparam int PW     = $clog2(FIFO_DEPTH + 1);
    localparam int PROD_W = PIX_W + WT_W;
    localparam int CSW    = PROD_W + $clog2(MAX_KERNEL + 1);
    localparam int TW     = CSW + $clog2(MAX_KERNEL + 1);
    localparam int MW     = RECIP_W + WT_W;

    // ---------------------------------------------------------------- registers
    logic [1:0]          type_reg;
    logic [2:0]          size_reg;
    logic [WT_W-1:0]     cw_reg;
    logic [12:0]         width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic       geo_clr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    // A new geometry starts a new frame.
    assign geo_clr = cfg_wr && ((cfg_idx == REG_KERNEL_SIZE) || (cfg_idx == REG_IMAGE_WIDTH)
                                || (cfg_idx == REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg   <= 2'd0;
            size_reg   <= 3'd3;
            cw_reg     <= WT_W'(32768);
            width_reg  <= 13'd1024;
            height_reg <= 16'd768;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_KERNEL_TYPE:   type_reg   <= pwdata[1:0];
                REG_KERNEL_SIZE:   size_reg   <= pwdata[2:0];
                REG_CENTER_WEIGHT: cw_reg     <= pwdata[WT_W-1:0];
                REG_IMAGE_WIDTH:   width_reg  <= pwdata[12:0];
                REG_IMAGE_HEIGHT:  height_reg <= pwdata[HEIGHT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_KERNEL_TYPE:   prdata = DATA_W'(type_reg);
            REG_KERNEL_SIZE:   prdata = DATA_W'(size_reg);
            REG_CENTER_WEIGHT: prdata = DATA_W'(cw_reg);
            REG_IMAGE_WIDTH:   prdata = DATA_W'(width_reg);
            REG_IMAGE_HEIGHT:  prdata = DATA_W'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- working geometry
    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [OW-1:0]       off;
    logic [LW-1:0]       delay;
    logic [WT_W-1:0]     ff_sat;

    always_comb
    begin
        // Zero width or height counts as one; width caps at the line store size.
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        // Even sizes round up to the next odd size; cap at the largest kernel.
        off    = (32'(size_reg[2:1]) > HALF) ? OW'(HALF) : OW'(size_reg[2:1]);
        delay  = LW'(32'(off) * 32'(w_eff) + 32'(off));
        ff_sat = (32'(cw_reg) > Q16_ONE) ? WT_W'(Q16_ONE) : cw_reg;
    end

    // -------------------------------------------------------------- weight table
    logic [WT_W-1:0]    mean_tab  [HALF+1];
    logic [RECIP_W-1:0] recip_tab [HALF+1];
    logic [WT_W-1:0]    bin_tab   [HALF+1][MAX_KERNEL][MAX_KERNEL];

    for (genvar o = 0; o <= HALF; o++)
    begin : g_off
        localparam int SIDE = 2 * o + 1;
        localparam int MEAN = Q16_ONE / (SIDE * SIDE);
        localparam longint ODIV = (SIDE * SIDE > 1) ? SIDE * SIDE - 1 : 1;
        localparam longint RECIP = (o == 0) ? 0 :
            ((longint'(1) << RECIP_SHIFT) + ODIV - 1) / ODIV;
        assign mean_tab[o]  = WT_W'(MEAN);
        assign recip_tab[o] = RECIP_W'(RECIP);
        for (genvar a = 0; a < MAX_KERNEL; a++)
        begin : g_age
            for (genvar d = 0; d < MAX_KERNEL; d++)
            begin : g_depth
                assign bin_tab[o][a][d] = WT_W'(binom_weight(o, a, d));
            end
        end
    end

    logic [MW-1:0]   other_prod;
    logic [WT_W-1:0] other_w;
    logic [WT_W-1:0] wt_next [MAX_KERNEL][MAX_KERNEL];
    logic [WT_W-1:0] wt_reg  [MAX_KERNEL][MAX_KERNEL];

    // Share the rest of 1.0 among the outer weights: multiply by a rounded-up reciprocal.
    assign other_prod = MW'(WT_W'(Q16_ONE) - ff_sat) * MW'(recip_tab[off]);
    assign other_w    = WT_W'(other_prod >> RECIP_SHIFT);

    // Table is indexed by window place: a is age (column), d is depth (row).
    always_comb
    begin
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            for (int d = 0; d < MAX_KERNEL; d++)
            begin
                wt_next[a][d] = '0;
                if ((a <= 2 * int'(off)) && (d <= 2 * int'(off)))
                begin
                    unique case (type_reg)
                        KT_WEIGHTED:
                        begin
                            wt_next[a][d] = ((a == int'(off)) && (d == int'(off))) ?
                                            ff_sat : other_w;
                        end
                        KT_BINOMIAL: wt_next[a][d] = bin_tab[off][a][d];
                        default:     wt_next[a][d] = mean_tab[off];
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wt_reg <= wt_next;
    end

    // ------------------------------------------------------------ frame counters
    logic [CW-1:0]       cin_reg,  cin_next;
    logic [ROW_W-1:0]    rin_reg,  rin_next;
    logic [LW-1:0]       lead_reg, lead_next;
    logic [CW-1:0]       ocol_reg, ocol_next;
    logic [HEIGHT_W-1:0] orow_reg, orow_next;
    logic [PW-1:0]       pend_reg, pend_next;

    logic             acc;
    logic             pop;
    logic             emit;
    logic             col_end;
    logic             ocol_end;
    logic             orow_end;
    logic             last_now;
    logic [PIX_W-1:0] pix_v;

    assign pixel_stall = (pend_reg == PW'(FIFO_DEPTH));
    assign acc         = pixel_valid && !pixel_stall;
    assign pop         = result_valid && !result_stall;

    // Output slot (r, c) leaves off rows and off columns behind its input slot.
    assign emit     = (lead_reg == delay);
    assign col_end  = (WW'(cin_reg) + WW'(1) == w_eff);
    assign ocol_end = (WW'(ocol_reg) + WW'(1) == w_eff);
    assign orow_end = (orow_reg == h_eff - HEIGHT_W'(1));
    assign last_now = emit && ocol_end && orow_end;
    // Drop the pixel on flush words and past the image end.
    assign pix_v    = (!flush && (rin_reg < ROW_W'(h_eff))) ? pixel : '0;

    always_comb
    begin
        cin_next  = cin_reg;
        rin_next  = rin_reg;
        lead_next = lead_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        priority if (geo_clr || (acc && last_now))
        begin
            cin_next  = '0;
            rin_next  = '0;
            lead_next = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (acc)
        begin
            if (col_end)
            begin
                cin_next = '0;
                rin_next = rin_reg + ROW_W'(1);
            end
            else
            begin
                cin_next = cin_reg + CW'(1);
            end
            if (emit)
            begin
                if (ocol_end)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + HEIGHT_W'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + CW'(1);
                end
            end
            else
            begin
                lead_next = lead_reg + LW'(1);
            end
        end
        // Reserve a queue entry for every word that will produce a result.
        pend_next = pend_reg + PW'(acc && emit) - PW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cin_reg  <= '0;
            rin_reg  <= '0;
            lead_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            cin_reg  <= cin_next;
            rin_reg  <= rin_next;
            lead_reg <= lead_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            pend_reg <= pend_next;
        end
    end

    // ------------------------------------------------- stage 1: line store access
    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [CW-1:0]       s1_ocol_reg;
    logic [HEIGHT_W-1:0] s1_orow_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_emit_reg <= emit;
            s1_last_reg <= last_now;
            s1_pix_reg  <= pix_v;
            s1_col_reg  <= cin_reg;
            s1_ocol_reg <= ocol_reg;
            s1_orow_reg <= orow_reg;
        end
    end

    logic [PIX_W-1:0] column [MAX_KERNEL];

    ibc_line_store #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_line_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (acc),
        .rd_col (cin_reg),
        .wr_en  (s1_valid_reg),
        .wr_col (s1_col_reg),
        .wr_pix (s1_pix_reg),
        .column (column)
    );

    // Zero padding: mask window rows and columns that fall outside the image.
    logic [ROW_W-1:0]      row_base;
    logic [WW:0]           col_base;
    logic [MAX_KERNEL-1:0] row_ok;
    logic [MAX_KERNEL-1:0] col_ok;

    always_comb
    begin
        row_base = ROW_W'(s1_orow_reg) + ROW_W'(off);
        col_base = (WW + 1)'(s1_ocol_reg) + (WW + 1)'(off);
        for (int k = 0; k < MAX_KERNEL; k++)
        begin
            row_ok[k] = (row_base >= ROW_W'(k)) &&
                        (row_base - ROW_W'(k) < ROW_W'(h_eff));
            col_ok[k] = (col_base >= (WW + 1)'(k)) &&
                        (col_base - (WW + 1)'(k) < (WW + 1)'(w_eff));
        end
    end

    // ------------------------------------------- stages 2 to 5: arithmetic pipe
    logic                  s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic                  s2_last_reg,  s3_last_reg,  s4_last_reg,  s5_last_reg;
    logic [MAX_KERNEL-1:0] s2_row_ok_reg;
    logic [MAX_KERNEL-1:0] s2_col_ok_reg;
    logic [TW-1:0]         total_reg;
    logic [TW-1:0]         total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg   <= s1_last_reg;
        s2_row_ok_reg <= row_ok;
        s2_col_ok_reg <= col_ok;
        s3_last_reg   <= s2_last_reg;
        s4_last_reg   <= s3_last_reg;
        s5_last_reg   <= s4_last_reg;
        total_reg     <= total_next;
    end

    // Row of window cells: cell a holds the column that entered a words ago.
    logic [PIX_W-1:0] win_col [MAX_KERNEL][MAX_KERNEL];
    logic [CSW-1:0]   col_sum [MAX_KERNEL];

    for (genvar a = 0; a < MAX_KERNEL; a++)
    begin : g_cell
        if (a == 0)
        begin : g_head
            ibc_cell #(
                .MAX_KERNEL (MAX_KERNEL)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (s1_valid_reg),
                .col_in   (column),
                .col_out  (win_col[a]),
                .wt       (wt_reg[a]),
                .col_ok   (s2_col_ok_reg[a]),
                .row_ok   (s2_row_ok_reg),
                .sum      (col_sum[a])
            );
        end
        else
        begin : g_body
            ibc_cell #(
                .MAX_KERNEL (MAX_KERNEL)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (s1_valid_reg),
                .col_in   (win_col[a-1]),
                .col_out  (win_col[a]),
                .wt       (wt_reg[a]),
                .col_ok   (s2_col_ok_reg[a]),
                .row_ok   (s2_row_ok_reg),
                .sum      (col_sum[a])
            );
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            total_next = total_next + TW'(col_sum[a]);
        end
    end

    // Drop the fraction, then saturate to the pixel range.
    logic [TW-WT_FRAC-1:0] scaled;
    logic [PIX_W-1:0]      result;

    assign scaled = total_reg[TW-1:WT_FRAC];
    assign result = (|scaled[TW-WT_FRAC-1:PIX_W]) ? '1 : scaled[PIX_W-1:0];

    ibc_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s5_valid_reg),
        .push_data (result),
        .push_last (s5_last_reg),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (blurred),
        .last      (last)
    );

endmodule

// ===== tb/image_blur_convolution_tb.sv =====
// Self-checking testbench for the image blur convolution block: stimulus, blur predictor, checks.

// Output word of the block as the predictor expects it.
typedef struct packed {
    logic [15:0] blurred;
    logic        last;
} blur_word_t;

// Tracks the blur state, predicts each output word and checks the words that leave the block.
class blur_scoreboard;
    logic [15:0] line_mem [6][4096];
    logic [15:0] win [7][7];          // [age][depth]
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned k_type;
    int unsigned k_size;
    int unsigned ff;
    int unsigned img_w;
    int unsigned img_h;
    blur_word_t  blur_q [$];
    int          errors;

    function new();
        foreach (line_mem[r, c]) line_mem[r][c] = '0;
        foreach (win[a, d]) win[a][d] = '0;
        col_cnt = 0;
        row_cnt = 0;
        k_type  = 0;
        k_size  = 3;
        ff      = 32768;
        img_w   = 1024;
        img_h   = 768;
        errors  = 0;
    endfunction

    function int pending();
        return blur_q.size();
    endfunction

    function void set_reg(int unsigned idx, logic [31:0] data);
        case (idx)
            ibc_pkg::REG_KERNEL_TYPE:   k_type = data[1:0];
            ibc_pkg::REG_KERNEL_SIZE:   begin k_size = data[2:0]; col_cnt = 0; row_cnt = 0; end
            ibc_pkg::REG_CENTER_WEIGHT: ff = data[16:0];
            ibc_pkg::REG_IMAGE_WIDTH:   begin img_w = data[12:0]; col_cnt = 0; row_cnt = 0; end
            ibc_pkg::REG_IMAGE_HEIGHT:  begin img_h = data[15:0]; col_cnt = 0; row_cnt = 0; end
            default: ;
        endcase
    endfunction

    // Q1.16 weight of kernel place (i, j) for side length sz.
    function longint unsigned kernel_weight(int unsigned sz, int unsigned i, int unsigned j);
        longint unsigned n;
        longint unsigned cw;
        longint unsigned bc [7];
        longint unsigned e;
        n = sz * sz;
        if (k_type == ibc_pkg::KT_WEIGHTED)
        begin
            cw = (ff > 65536) ? 65536 : ff;
            if (i == sz / 2 && j == sz / 2)
                return cw;
            return (n > 1) ? (65536 - cw) / (n - 1) : 0;
        end
        if (k_type == ibc_pkg::KT_BINOMIAL)
        begin
            foreach (bc[m]) bc[m] = 0;
            bc[0] = 1;
            for (int m = 1; m < sz; m++)
                for (int q = m; q >= 1; q--)
                    bc[q] += bc[q - 1];
            e = 2 * (sz - 1);
            return (bc[i] * bc[j]) << (16 - e);
        end
        return 65536 / n;
    endfunction

    // Note an accepted input word and queue the output word it causes, if any.
    function void note_pixel(logic [15:0] px, logic fl);
        longint unsigned w_eff, h_eff, off, sz, total, p, dly, q, acc;
        longint r, c, rr, cc;
        int unsigned cidx, ridx;
        logic [15:0] v;
        blur_word_t bw;
        w_eff = (img_w == 0) ? 1 : ((img_w > 4096) ? 4096 : img_w);
        h_eff = (img_h == 0) ? 1 : img_h;
        off   = (k_size / 2 > 3) ? 3 : k_size / 2;
        sz    = 2 * off + 1;
        dly   = off * w_eff + off;
        total = h_eff * w_eff;
        p     = longint'(row_cnt) * w_eff + col_cnt;
        cidx  = (col_cnt < 4096) ? col_cnt : 0;
        ridx  = row_cnt % 6;
        v     = (!fl && p < total) ? px : 16'd0;
        for (int a = 6; a >= 1; a--)
            for (int d = 0; d < 7; d++)
                win[a][d] = win[a - 1][d];
        win[0][0] = v;
        for (int k = 1; k <= 6; k++)
            win[0][k] = line_mem[(ridx + 6 - k) % 6][cidx];
        line_mem[ridx][cidx] = v;
        if (p >= dly && p - dly < total)
        begin
            q   = p - dly;
            r   = q / w_eff;
            c   = q % w_eff;
            acc = 0;
            for (int i = 0; i < sz; i++)
            begin
                rr = r + i - longint'(off);
                if (rr < 0 || rr >= longint'(h_eff))
                    continue;
                for (int j = 0; j < sz; j++)
                begin
                    cc = c + j - longint'(off);
                    if (cc < 0 || cc >= longint'(w_eff))
                        continue;
                    acc += kernel_weight(sz, i, j) * win[2 * off - j][2 * off - i];
                end
            end
            acc        = acc >> 16;
            bw.blurred = (acc > 65535) ? 16'hFFFF : acc[15:0];
            bw.last    = (q == total - 1);
            blur_q.push_back(bw);
            if (q == total - 1)
            begin
                col_cnt = 0;
                row_cnt = 0;
                return;
            end
        end
        col_cnt++;
        if (col_cnt >= w_eff)
        begin
            col_cnt = 0;
            row_cnt++;
        end
    endfunction

    // Check an output word against the oldest prediction.
    function void check_result(logic [15:0] blurred, logic last);
        blur_word_t bw;
        if (blur_q.size() == 0)
        begin
            $error("unexpected output word blurred=%0d last=%0d", blurred, last);
            errors++;
            return;
        end
        bw = blur_q.pop_front();
        if (blurred !== bw.blurred)
        begin
            $error("blurred: expected %0d, actual %0d", bw.blurred, blurred);
            errors++;
        end
        if (last !== bw.last)
        begin
            $error("last: expected %0d, actual %0d", bw.last, last);
            errors++;
        end
    endfunction
endclass

module image_blur_convolution_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ibc_pkg::ADDR_W-1:0] paddr;
    logic [ibc_pkg::DATA_W-1:0] pwdata;
    logic [ibc_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       pixel_valid;
    logic                       pixel_stall;
    logic [15:0]                pixel;
    logic                       flush;
    logic                       result_valid;
    logic                       result_stall;
    logic [15:0]                blurred;
    logic                       last;

    blur_scoreboard sb;
    bit             no_gaps;     // set for stretches with no idling on either side
    bit             hold_req;    // ask the receiver for one long hold-off
    int             words_sent;

    image_blur_convolution u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .flush        (flush),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .blurred      (blurred),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #50ms;
        $display("FAIL image_blur_convolution");
        $finish;
    end

    // Monitor both channels: note accepted input words, check accepted output words.
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            sb.note_pixel(pixel, flush);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(blurred, last);
    end

    // Receiver: stall for a random number of cycles before each word; hold off long on request.
    initial
    begin
        int n;
        result_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 8);
            if (hold_req)
            begin
                n        = 300;
                hold_req = 1'b0;
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    // Write one register with a setup phase and then an access phase.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ibc_pkg::ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Wait until every predicted word has left, then let the pipeline settle.
    task automatic drain_block();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Offer one input word after a random gap and hold it until taken.
    task automatic send_word(input logic [15:0] px, input logic fl);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 8);
        if (n > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        flush       <= fl;
        do @(posedge clk); while (!(pixel_valid && !pixel_stall));
        words_sent++;
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Program all registers while idle.
    task automatic set_config(input int unsigned kt, input int unsigned ks,
                              input int unsigned cw, input int unsigned w,
                              input int unsigned h);
        drain_block();
        reg_write(ibc_pkg::REG_KERNEL_TYPE, kt);
        reg_write(ibc_pkg::REG_KERNEL_SIZE, ks);
        reg_write(ibc_pkg::REG_CENTER_WEIGHT, cw);
        reg_write(ibc_pkg::REG_IMAGE_WIDTH, w);
        reg_write(ibc_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // Stream one frame of random pixels with occasional flush words, then mostly flush words to drain the bottom rows.
    // A cut frame stops early; the next geometry write restarts the counters.
    task automatic run_frame(input bit cut);
        int unsigned w_eff, h_eff, off, total, words;
        w_eff = (sb.img_w == 0) ? 1 : ((sb.img_w > 4096) ? 4096 : sb.img_w);
        h_eff = (sb.img_h == 0) ? 1 : sb.img_h;
        off   = (sb.k_size / 2 > 3) ? 3 : sb.k_size / 2;
        total = w_eff * h_eff;
        words = total + off * w_eff + off;
        if (cut)
            words = $urandom_range(1, words);
        for (int unsigned i = 0; i < words; i++)
        begin
            if (i < total)
                send_word(rand_pixel(), $urandom_range(0, 99) < 7);
            else
                send_word(rand_pixel(), $urandom_range(0, 99) < 85);
        end
    endtask

    initial
    begin
        int unsigned frame_no;
        sb          = new();
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        flush       <= 1'b0;
        no_gaps     = 1'b0;
        hold_req    = 1'b0;
        words_sent  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bright frame with a flush inside and a pixel past the end.
        set_config(0, 3, 32768, 3, 2);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h1234, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        // Centre weight above one on a single pixel.
        set_config(ibc_pkg::KT_WEIGHTED, 1, 131071, 1, 1);
        send_word(16'hFFFF, 1'b0);
        // Zero width, height and size with the unknown kernel type.
        set_config(3, 0, 0, 0, 0);
        send_word(16'hABCD, 1'b0);
        // Widest binomial kernel on a tiny image, mostly padding.
        set_config(ibc_pkg::KT_BINOMIAL, 7, 65536, 2, 2);
        for (int i = 0; i < 13; i++)
            send_word(16'hFFFF, i == 5);

        // Random frames: small geometry, every kernel, a few extremes.
        frame_no = 0;
        while (words_sent < 1150)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (frame_no == 3)
            begin
                set_config(0, 5, 0, 24, 10);
                no_gaps  = 1'b1;
                hold_req = 1'b1;
                run_frame(1'b0);
                no_gaps  = 1'b0;
            end
            else if (frame_no == 6)
            begin
                set_config(ibc_pkg::KT_BINOMIAL, 7, 0, 40, 1);
                run_frame(1'b0);
            end
            else if (frame_no == 9)
            begin
                set_config(ibc_pkg::KT_WEIGHTED, 6, 0, 1, 60);
                run_frame(1'b0);
            end
            else
            begin
                set_config($urandom_range(0, 3), $urandom_range(0, 7),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                       : $urandom_range(0, 65536),
                           $urandom_range(0, 12), $urandom_range(0, 9));
                run_frame($urandom_range(0, 9) == 0);
            end
            frame_no++;
        end

        drain_block();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS image_blur_convolution");
        else
            $display("FAIL image_blur_convolution");
        $finish;
    end
endmodule
